/* hw/rtl/bde_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants for the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic latch;
        logic wr_front;
        logic wr_back;
        logic rd_front;
        logic rd_back;
        logic rd_dump_first;
        logic rd_dump_next;
        logic load_ok;
        logic load_empty;
        logic load_full;
        logic load_data;
        logic data_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/bde_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* hw/rtl/bde_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bde_dpath
// Deque datapath: ring store, head and count, input latch, result register.
// ----------------------------------------------------------------------------
module bde_dpath import bde_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire op_t               in_op,
    input  wire logic [DATA_W-1:0] in_value,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] out_item,
    output status_t                out_status,
    output logic                   out_last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    op_t               op_reg;
    logic [DATA_W-1:0] value_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_item_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  head_dec, head_inc, k_inc, cnt_m1, waddr, raddr;
    logic [CNT_W-1:0]  cnt_dec;
    logic [DATA_W-1:0] rdata;
    logic              we, re, load, out_free;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(CAPACITY))
        begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign k_inc    = k_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign cnt_m1   = cnt_dec[IDX_W-1:0];

    assign we    = cmd.wr_front | cmd.wr_back;
    assign re    = cmd.rd_front | cmd.rd_back | cmd.rd_dump_first | cmd.rd_dump_next;
    assign waddr = cmd.wr_front ? head_dec : wrap_add(head_reg, count_reg[IDX_W-1:0]);

    always_comb
    begin
        raddr = head_reg;
        if (cmd.rd_back)
        begin
            raddr = wrap_add(head_reg, cnt_m1);
        end
        else if (cmd.rd_dump_next)
        begin
            raddr = wrap_add(head_reg, k_inc);
        end
    end

    bde_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.wr_front)
        begin
            head_next = head_dec;
        end
        else if (cmd.rd_front)
        begin
            head_next = head_inc;
        end
        if (we)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rd_front || cmd.rd_back)
        begin
            count_next = cnt_dec;
        end
        if (cmd.rd_dump_first)
        begin
            k_next = '0;
        end
        else if (cmd.rd_dump_next)
        begin
            k_next = k_inc;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign load     = cmd.load_ok | cmd.load_empty | cmd.load_full | cmd.load_data;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (load)
        begin
            out_item_reg   <= cmd.load_data ? rdata : '0;
            out_status_reg <= cmd.load_empty ? ST_EMPTY :
                              (cmd.load_full ? ST_FULL : ST_OK);
            out_last_reg   <= cmd.load_data ? cmd.data_last : 1'b1;
        end
    end

    assign sts.op        = op_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg >= CAP_CNT);
    assign sts.out_free  = out_free;
    assign sts.dump_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

/* hw/rtl/bde_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ctrl
// Deque controller: accepts one beat, sequences store access and results.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                    case (sts.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (sts.full)
                            begin
                                cmd.load_full = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_front = (sts.op == OP_PUSH_FRONT);
                                cmd.wr_back  = (sts.op == OP_PUSH_BACK);
                                cmd.load_ok  = 1'b1;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_front = (sts.op == OP_POP_FRONT);
                                cmd.rd_back  = (sts.op == OP_POP_BACK);
                                state_next   = S_READ;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_dump_first = 1'b1;
                                state_next        = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    cmd.data_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    cmd.data_last = sts.dump_last;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_dump_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule
`default_nettype wire

/* hw/rtl/bounded_deque_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// Push and error results are loaded into the result register from the execute
// state; pops first take one registered RAM read. A dump issues its first read
// in the execute state, then loads one beat per cycle on the single RAM read
// port while the output is free. One item at a time: a new input beat is taken
// only once the last operation is finished; unused codes load no result.
// Reset clears head, count and the result valid; the store is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_engine import bde_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,  // value
    input  wire logic [OP_W-1:0]   s_axis_tuser,  // operation
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [DATA_W-1:0] m_axis_tdata,  // item
    output logic      [STAT_W-1:0] m_axis_tuser,  // status
    output logic                   m_axis_tlast
);

    cmd_t    cmd;
    sts_t    sts;
    status_t out_status;

    bde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bde_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (op_t'(s_axis_tuser)),
        .in_value   (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (m_axis_tdata),
        .out_status (out_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = out_status;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_ok || cmd.load_empty || cmd.load_full || cmd.load_data) |-> sts.out_free)
        else $error("result loaded over a pending beat");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(cmd.wr_front || cmd.wr_back || cmd.rd_front || cmd.rd_back ||
                            cmd.rd_dump_first || cmd.rd_dump_next))
        else $error("store access while idle");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_front, cmd.wr_back, cmd.rd_front, cmd.rd_back,
                  cmd.rd_dump_first, cmd.rd_dump_next}))
        else $error("conflicting store commands");

    a_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.full && sts.empty))
        else $error("count both full and empty");

endmodule
`default_nettype wire

/* dv/bounded_deque_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_checker
// Watches both stream ports of the deque engine, keeps its own copy of the
// ring store, front position and fill count, works out the result beats of
// every accepted operation and compares them in order with the output beats.
// ----------------------------------------------------------------------------
module bounded_deque_checker import bde_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]   s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0] m_tuser,
    input  logic              m_tlast,
    output int                errors,
    output int                answers_left,
    output int                held,
    output int                beats_checked,
    output int                full_seen,
    output int                empty_seen
);

    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        status_t                  status;
        logic                     last;
    } deque_answer_t;

    deque_answer_t            answers_due[$];
    logic signed [DATA_W-1:0] ring[CAPACITY];
    logic [5:0]               front_pos;
    logic [6:0]               fill_cnt;

    initial
    begin
        errors        = 0;
        beats_checked = 0;
        full_seen     = 0;
        empty_seen    = 0;
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic owe(logic signed [DATA_W-1:0] item, status_t status, logic last);
        deque_answer_t a;
        a.item   = item;
        a.status = status;
        a.last   = last;
        answers_due.push_back(a);
    endtask

    function automatic logic [5:0] slot_of(int ofs);
        return 6'((int'(front_pos) + ofs) % CAPACITY);
    endfunction

    task automatic apply_deque_op(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] val);
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_cnt >= CAPACITY)
                    owe('0, ST_FULL, 1'b1);
                else
                begin
                    if (code == OP_PUSH_FRONT)
                    begin
                        front_pos = 6'((int'(front_pos) + CAPACITY - 1) % CAPACITY);
                        ring[front_pos] = val;
                    end
                    else
                        ring[slot_of(fill_cnt)] = val;
                    fill_cnt = fill_cnt + 1'b1;
                    owe('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_cnt == 0)
                    owe('0, ST_EMPTY, 1'b1);
                else
                begin
                    if (code == OP_POP_FRONT)
                    begin
                        owe(ring[slot_of(0)], ST_OK, 1'b1);
                        front_pos = 6'((int'(front_pos) + 1) % CAPACITY);
                    end
                    else
                        owe(ring[slot_of(fill_cnt - 1)], ST_OK, 1'b1);
                    fill_cnt = fill_cnt - 1'b1;
                end
            end
            OP_DUMP:
            begin
                if (fill_cnt == 0)
                    owe('0, ST_EMPTY, 1'b1);
                else
                    for (int k = 0; k < fill_cnt; k++)
                        owe(ring[slot_of(k)], ST_OK, k + 1 == fill_cnt);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_answer_t want;
        if (!rst_n)
        begin
            answers_due.delete();
            front_pos = '0;
            fill_cnt  = '0;
            answers_left <= 0;
            held         <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (m_tuser == ST_FULL)
                    full_seen++;
                if (m_tuser == ST_EMPTY)
                    empty_seen++;
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat item=%0d status=%0d last=%0b",
                                              $signed(m_tdata), m_tuser, m_tlast));
                else
                begin
                    want = answers_due.pop_front();
                    if ($signed(m_tdata) != want.item)
                        report_mismatch($sformatf("item got %0d want %0d",
                                                  $signed(m_tdata), want.item));
                    if (m_tuser != want.status)
                        report_mismatch($sformatf("status got %0d want %s",
                                                  m_tuser, want.status.name()));
                    if (m_tlast != want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready)
                apply_deque_op(s_tuser, $signed(s_tdata));
            answers_left <= answers_due.size();
            held         <= fill_cnt;
        end
    end

endmodule

/* dv/tb_bounded_deque_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_engine
// Drives pushes, pops and dumps into the deque engine: a short directed set,
// a fill to capacity and a drain to empty, then random phases with varied
// push/pop balance and sender/receiver idling, one with a long output hold.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bounded_deque_engine;
    import bde_pkg::*;

    localparam int              CAPACITY      = CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;
    localparam int              HOLD_CYCLES   = 300;
    localparam int              QUIET_LIMIT   = 3000;
    localparam int              PHASE_ITEMS   = 44;
    localparam int              N_PHASES      = 6;
    localparam int              IDLE_NONE     = 0;
    localparam int              IDLE_SEND     = 1;
    localparam int              IDLE_RECV     = 2;
    localparam int              IDLE_BOTH     = 3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]   s_tuser   = '0;
    logic              m_tready  = 1'b0;
    logic              hold_req  = 1'b0;
    int                stall_pct = 0;
    int                send_idle = 0;
    int                hold_left = 0;
    int                quiet     = 0;
    int                ops_sent  = 0;

    wire               s_tready;
    wire               m_tvalid;
    wire  [DATA_W-1:0] m_tdata;
    wire  [STAT_W-1:0] m_tuser;
    wire               m_tlast;

    int chk_errors, answers_left, held, beats_checked, full_seen, empty_seen;

    int phase_idle[N_PHASES] = '{IDLE_SEND, IDLE_RECV, IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
    int phase_push[N_PHASES] = '{70, 30, 60, 50, 80, 20};

    bounded_deque_engine #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // value
        .s_axis_tuser  (s_tuser),   // operation
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // item
        .m_axis_tuser  (m_tuser),   // status
        .m_axis_tlast  (m_tlast)
    );

    bounded_deque_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (chk_errors),
        .answers_left  (answers_left),
        .held          (held),
        .beats_checked (beats_checked),
        .full_seen     (full_seen),
        .empty_seen    (empty_seen)
    );

    always #5 clk = ~clk;

    // output side: random stalls, or a long hold when requested
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
        else
            quiet = 0;
    end

    task automatic set_idle(int mode);
        send_idle = (mode == IDLE_SEND) ? 81 : (mode == IDLE_BOTH) ? 11 : 0;
        stall_pct <= (mode == IDLE_RECV) ? 81 : (mode == IDLE_BOTH) ? 11 : 0;
    endtask

    task automatic offer(logic [OP_W-1:0] code, logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
        if (code <= OP_DUMP)
            ops_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (answers_left != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(int push_pct);
        int r = $urandom_range(99);
        if (r < 3)
            return OP_UNUSED_LO + OP_W'($urandom_range(2));
        if (r < 9)
            return OP_DUMP;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    initial
    begin
        logic [OP_W-1:0] code;
        int              n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        offer(OP_DUMP, $urandom);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_POP_BACK, $urandom);
        offer(OP_UNUSED_LO, $urandom);
        offer(OP_PUSH_BACK, 32'h7FFF_FFFF);
        offer(OP_PUSH_FRONT, 32'h8000_0000);
        offer(OP_PUSH_BACK, 32'hFFFF_FFFF);
        offer(OP_PUSH_FRONT, 32'h0000_0000);
        offer(OP_UNUSED_MID, $urandom);
        offer(OP_DUMP, $urandom);
        offer(OP_POP_BACK, $urandom);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_UNUSED_HI, $urandom);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_POP_BACK, $urandom);
        offer(OP_DUMP, $urandom);
        offer(OP_PUSH_FRONT, 32'h5555_5555);
        offer(OP_PUSH_BACK, 32'hAAAA_AAAA);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_POP_BACK, $urandom);
        wait_drained();

        // fill from both ends until full, then hit it from both sides
        while (held < CAPACITY)
            offer($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        offer(OP_PUSH_FRONT, $urandom);
        offer(OP_PUSH_BACK, $urandom);
        offer(OP_DUMP, $urandom);
        wait_drained();

        set_idle(IDLE_BOTH);
        while (held > 0)
            offer($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        offer(OP_POP_FRONT, $urandom);
        offer(OP_POP_BACK, $urandom);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_idle(phase_idle[p]);
            if (phase_idle[p] == IDLE_NONE)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                code = pick_op(phase_push[p]);
                offer(code, $urandom);
                if (code <= OP_DUMP)
                    n++;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d operations and %0d result beats, incl. fill to capacity,",
                 ops_sent, beats_checked);
        $display("dump at capacity, %0d full and %0d empty results, a %0d-cycle output hold.",
                 full_seen, empty_seen, HOLD_CYCLES);
        if (chk_errors == 0 && answers_left == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bde_pkg.sv
hw/rtl/bde_ram.sv
hw/rtl/bde_dpath.sv
hw/rtl/bde_ctrl.sv
hw/rtl/bounded_deque_engine.sv
dv/bounded_deque_checker.sv
dv/tb_bounded_deque_engine.sv
